### hw/rtl/vcu_pkg.sv
// Shared types and constants for the vector clock unit.
// No dependencies; imported by vcu_ctrl, vcu_datapath and vector_clock_unit.
package vcu_pkg;

    localparam int NUM_PROCS   = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int IDX_WIDTH   = 3;
    localparam int OUT_WIDTH   = 32;
    localparam int REMOTE_WIDTH = 32;
    localparam int PROC_IDX_W  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int VAL_WIDTH   = (COUNT_WIDTH > REMOTE_WIDTH) ? COUNT_WIDTH : REMOTE_WIDTH;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [1:0] {
        MODE_LOCAL   = 2'd0,
        MODE_MERGE   = 2'd1,
        MODE_COMPARE = 2'd2,
        MODE_READ    = 2'd3
    } mode_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } vcu_cmd_t;

endpackage

### hw/rtl/vcu_ctrl.sv
// Controller for the vector clock unit: input and output handshakes.
// Depends on vcu_pkg; drives the command struct of vcu_datapath.
module vcu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output vcu_pkg::vcu_cmd_t cmd
);
    import vcu_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign cmd.capture = s_valid && (state_reg == ST_IDLE);
    assign cmd.execute = (state_reg == ST_EXEC) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/vcu_datapath.sv
// Datapath for the vector clock unit: clock entries, compare flags and result register.
// Depends on vcu_pkg; sequenced by vcu_ctrl through the command struct.
module vcu_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  vcu_pkg::vcu_cmd_t              cmd,
    input  logic                           cfg_wr_en,
    input  logic [vcu_pkg::IDX_WIDTH-1:0]  cfg_wr_data,
    input  logic [1:0]                     s_mode,
    input  logic [vcu_pkg::IDX_WIDTH-1:0]  s_elem_index,
    input  logic [vcu_pkg::REMOTE_WIDTH-1:0] s_remote_count,
    input  logic                           s_last_elem,
    output logic [vcu_pkg::OUT_WIDTH-1:0]  m_entry_value,
    output logic                           m_verdict_valid,
    output logic                           m_happened_before,
    output logic                           m_saturated,
    output logic                           m_bad_index
);
    import vcu_pkg::*;

    count_t                  entries_reg [NUM_PROCS];
    logic                    seen_greater_reg;
    logic                    seen_less_reg;
    logic [IDX_WIDTH-1:0]    own_index_reg;

    mode_t                   mode_reg;
    logic [IDX_WIDTH-1:0]    idx_reg;
    logic [REMOTE_WIDTH-1:0] remote_reg;
    logic                    last_reg;

    logic [OUT_WIDTH-1:0]    entry_value_reg;
    logic                    verdict_reg;
    logic                    hb_reg;
    logic                    sat_reg;
    logic                    bad_reg;

    logic [IDX_WIDTH-1:0]    sel_idx;
    logic [PROC_IDX_W-1:0]   addr;
    logic                    bad;
    logic                    own_hit;
    logic                    do_inc;
    logic                    at_max;
    logic                    write_en;
    count_t                  old_val;
    count_t                  inc_val;
    count_t                  remote_sat;
    count_t                  new_val;
    count_t                  value;
    logic                    is_greater;
    logic                    is_less;
    logic                    seen_greater_next;
    logic                    seen_less_next;

    always_comb begin
        sel_idx    = (mode_reg == MODE_LOCAL) ? own_index_reg : idx_reg;
        bad        = (int'(sel_idx) >= NUM_PROCS);
        addr       = PROC_IDX_W'(sel_idx);
        old_val    = entries_reg[addr];
        own_hit    = (idx_reg == own_index_reg);
        remote_sat = (VAL_WIDTH'(remote_reg) > VAL_WIDTH'(CNT_MAX)) ? CNT_MAX
                                                                     : COUNT_WIDTH'(remote_reg);
        at_max     = (old_val == CNT_MAX);
        do_inc     = 1'b0;
        write_en   = 1'b0;
        new_val    = old_val;
        value      = '0;
        case (mode_reg)
            MODE_LOCAL: begin
                do_inc   = !bad;
                write_en = !bad;
            end
            MODE_MERGE: begin
                do_inc   = !bad && own_hit;
                write_en = !bad;
            end
            default: begin
            end
        endcase
        inc_val = (do_inc && !at_max) ? old_val + COUNT_WIDTH'(1) : old_val;
        if (mode_reg == MODE_MERGE && remote_sat > inc_val) begin
            new_val = remote_sat;
        end else begin
            new_val = inc_val;
        end
        if (!bad) begin
            value = write_en ? new_val : old_val;
        end
        is_greater = !bad && (old_val > remote_sat);
        is_less    = !bad && (old_val < remote_sat);
        seen_greater_next = seen_greater_reg;
        seen_less_next    = seen_less_reg;
        if (mode_reg == MODE_COMPARE) begin
            seen_greater_next = seen_greater_reg || is_greater;
            seen_less_next    = seen_less_reg || is_less;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg   <= mode_t'(s_mode);
            idx_reg    <= s_elem_index;
            remote_reg <= s_remote_count;
            last_reg   <= s_last_elem;
        end
        if (cmd.execute) begin
            if (write_en) begin
                entries_reg[addr] <= new_val;
            end
            entry_value_reg <= OUT_WIDTH'(value);
            verdict_reg     <= (mode_reg == MODE_COMPARE) && last_reg;
            hb_reg          <= (mode_reg == MODE_COMPARE) && last_reg
                               && seen_less_next && !seen_greater_next;
            sat_reg         <= do_inc && at_max;
            bad_reg         <= bad;
        end
        if (!aresetn) begin
            for (int i = 0; i < NUM_PROCS; i++) begin
                entries_reg[i] <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_greater_reg <= 1'b0;
            seen_less_reg    <= 1'b0;
            own_index_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                own_index_reg <= cfg_wr_data;
            end
            if (cmd.execute) begin
                if (mode_reg == MODE_COMPARE && last_reg) begin
                    seen_greater_reg <= 1'b0;
                    seen_less_reg    <= 1'b0;
                end else begin
                    seen_greater_reg <= seen_greater_next;
                    seen_less_reg    <= seen_less_next;
                end
            end
        end
    end

    assign m_entry_value     = entry_value_reg;
    assign m_verdict_valid   = verdict_reg;
    assign m_happened_before = hb_reg;
    assign m_saturated       = sat_reg;
    assign m_bad_index       = bad_reg;

endmodule

### hw/rtl/vector_clock_unit.sv
// Top level of the vector clock unit: controller, datapath and assertions.
// Depends on vcu_pkg, vcu_ctrl and vcu_datapath.
//
//   Channel  Ports                                             Direction
//   s_       s_valid/s_ready, mode, elem_index, remote_count,  in
//            last_elem
//   m_       m_valid/m_ready, entry_value, verdict_valid,      out
//            happened_before, saturated, bad_index
//   cfg_     cfg_wr_en, cfg_wr_data (own_index)                in
//
// Each item is captured first and then, in the update step, updates the entry
// register file and loads the result register.
// A new item is accepted while the previous result still waits for m_ready.
// The update step waits while the result register is full and not taken.
// Reset is synchronous and active low; it clears every entry and both flags.
module vector_clock_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [vcu_pkg::IDX_WIDTH-1:0]    cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_mode,
    input  logic [vcu_pkg::IDX_WIDTH-1:0]    s_elem_index,
    input  logic [vcu_pkg::REMOTE_WIDTH-1:0] s_remote_count,
    input  logic                             s_last_elem,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [vcu_pkg::OUT_WIDTH-1:0]    m_entry_value,
    output logic                             m_verdict_valid,
    output logic                             m_happened_before,
    output logic                             m_saturated,
    output logic                             m_bad_index
);
    import vcu_pkg::*;

    vcu_cmd_t cmd;

    vcu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    vcu_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_mode            (s_mode),
        .s_elem_index      (s_elem_index),
        .s_remote_count    (s_remote_count),
        .s_last_elem       (s_last_elem),
        .m_entry_value     (m_entry_value),
        .m_verdict_valid   (m_verdict_valid),
        .m_happened_before (m_happened_before),
        .m_saturated       (m_saturated),
        .m_bad_index       (m_bad_index)
    );

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Second item accepted while one is in progress.");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> ##1 m_valid)
        else $error("No result after the update step.");

    a_hb_needs_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_verdict_valid |-> !m_happened_before)
        else $error("Happened-before reported without a verdict.");

    a_bad_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_index |-> (m_entry_value == '0) && !m_saturated)
        else $error("Bad index item returned a value.");

endmodule
